// File: sv/kpsm_pkg.sv
`default_nettype none

package kpsm_pkg;

    localparam int KEY_CODE_W = 6;
    localparam int HOLD_W     = 8;
    localparam int IDLE_W     = 12;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 16;

    // Hold counter ceiling.
    localparam logic [HOLD_W-1:0] HOLD_MAX = 8'hFF;

    // Register indexes on the config port.
    localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO    = 2'd2;

    localparam logic [KEY_CODE_W-1:0] RST_PROGRAM_KEY = 6'd6;
    localparam logic [HOLD_W-1:0]     RST_HOLD_THRESH = 8'd100;
    localparam logic [IDLE_W-1:0]     RST_IDLE_TMO    = 12'd2500;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_LEARN = 2'd2
    } action_t;

    // Result item, packed so debounced_key lands in the low bits.
    typedef struct packed {
        logic                  power_down;
        logic                  repeat_frame;
        action_t               action;
        logic                  learn_mode;
        logic [KEY_CODE_W-1:0] debounced_key;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// File: sv/kpsm_encode.sv
`default_nettype none

// Priority encoder: lowest column first, then lowest row; 0 when no key.
module kpsm_encode #(
    parameter int KEY_COLUMNS = 4,
    parameter int KEY_ROWS    = 8
) (
    input  wire logic [8*KEY_COLUMNS-1:0]           matrix,
    output logic      [kpsm_pkg::KEY_CODE_W-1:0]    code
);

    always_comb
    begin
        code = '0;
        // Walk from the highest position down so the lowest one wins.
        for (int c = KEY_COLUMNS - 1; c >= 0; c--)
        begin
            for (int r = KEY_ROWS - 1; r >= 0; r--)
            begin
                if (matrix[8*c + r])
                begin
                    code = kpsm_pkg::KEY_CODE_W'(8*c + r + 1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/keypad_scan_mode_control.sv
`default_nettype none

// Keypad scanner with debounce and send/learn mode control. Each input item
// is one scan tick: a snapshot of the key matrix, bit 8*column+row set for a
// pressed key. The snapshot is priority-encoded (lowest column, then lowest
// row) to a code 1..32, and a code counts as the debounced key only when two
// consecutive ticks agree. Holding the program key for more than
// hold_threshold ticks enters learn mode; more than idle_timeout idle ticks
// in learn mode return to send mode. Every tick yields one result item.
// Rate: one item per clock cycle while the receiver takes results; the input
// register holds the encoded code, then the result register holds the result.
// The mode, hold and idle counters update as the result register loads.
// Config writes take effect on the next clock and are meant for idle times.
module keypad_scan_mode_control #(
    parameter int KEY_COLUMNS = 4,
    parameter int KEY_ROWS    = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Scan tick in
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [8*KEY_COLUMNS-1:0]            s_tdata,   // [..0] key_matrix

    // Result out
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [5:0] debounced_key, [6] learn_mode, [8:7] action, [9] repeat_frame,
    // [10] power_down, rest zero
    output logic [kpsm_pkg::OUT_DATA_W-1:0]          m_tdata,

    // Config write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [kpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kpsm_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int CW = kpsm_pkg::KEY_CODE_W;
    localparam int HW = kpsm_pkg::HOLD_W;
    localparam int IW = kpsm_pkg::IDLE_W;

    // ---------------- configuration registers ----------------
    logic [CW-1:0] program_key_reg;
    logic [HW-1:0] hold_thresh_reg;
    logic [IW-1:0] idle_tmo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_key_reg <= kpsm_pkg::RST_PROGRAM_KEY;
            hold_thresh_reg <= kpsm_pkg::RST_HOLD_THRESH;
            idle_tmo_reg    <= kpsm_pkg::RST_IDLE_TMO;
        end
        else if (cfg_wr_en)
        begin
            // Index 3 is not a register; writes there are dropped.
            if (cfg_index == kpsm_pkg::REG_PROGRAM_KEY)
                program_key_reg <= cfg_wdata[CW-1:0];
            if (cfg_index == kpsm_pkg::REG_HOLD_THRESH)
                hold_thresh_reg <= cfg_wdata[HW-1:0];
            if (cfg_index == kpsm_pkg::REG_IDLE_TMO)
                idle_tmo_reg    <= cfg_wdata[IW-1:0];
        end
    end

    // ---------------- pipeline handshake ----------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_adv;     // result register can load
    logic in_adv;      // input register can load

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;
    assign m_tvalid = out_valid_reg;

    // ---------------- stage 1: encode into input register ----------------
    logic [CW-1:0] raw_code;
    logic [CW-1:0] raw_reg;

    kpsm_encode #(
        .KEY_COLUMNS (KEY_COLUMNS),
        .KEY_ROWS    (KEY_ROWS)
    ) u_encode (
        .matrix (s_tdata),
        .code   (raw_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_adv)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && s_tvalid)
            raw_reg <= raw_code;
    end

    // ---------------- stage 2: debounce and mode control ----------------
    logic [CW-1:0] prev_raw_reg,  prev_raw_next;
    logic          mode_reg,      mode_next;
    logic [IW-1:0] idle_cnt_reg,  idle_cnt_next;
    logic [HW-1:0] hold_cnt_reg,  hold_cnt_next;
    logic [CW-1:0] last_sent_reg, last_sent_next;
    kpsm_pkg::result_t res_next, out_reg;

    logic [CW-1:0] deb;
    logic          idle_tick;
    logic          step;

    assign step      = in_valid_reg && out_adv;
    assign deb       = (raw_reg == prev_raw_reg) ? raw_reg : '0;
    assign idle_tick = (raw_reg == '0) && (prev_raw_reg == '0);

    always_comb
    begin
        prev_raw_next  = raw_reg;
        mode_next      = mode_reg;
        idle_cnt_next  = idle_cnt_reg;
        hold_cnt_next  = hold_cnt_reg;
        last_sent_next = last_sent_reg;
        res_next       = '0;

        // Idle handling: sleep request in send mode, timeout in learn mode.
        if (idle_tick)
        begin
            if (!mode_reg)
            begin
                res_next.power_down = 1'b1;
            end
            else if (idle_cnt_reg >= idle_tmo_reg)
            begin
                idle_cnt_next       = '0;
                mode_next           = 1'b0;
                res_next.power_down = 1'b1;
            end
            else
            begin
                idle_cnt_next = idle_cnt_reg + 1'b1;
            end
        end
        else
        begin
            idle_cnt_next = '0;
        end

        // Key handling.
        if (deb != '0)
        begin
            if (deb == program_key_reg)
            begin
                mode_next = 1'b0;
                if (hold_cnt_reg != kpsm_pkg::HOLD_MAX)
                    hold_cnt_next = hold_cnt_reg + 1'b1;
                if (hold_cnt_next > hold_thresh_reg)
                begin
                    idle_cnt_next = '0;
                    mode_next     = 1'b1;
                end
            end
            else if (!mode_next)
            begin
                res_next.action       = kpsm_pkg::ACT_SEND;
                res_next.repeat_frame = (deb == last_sent_reg);
                last_sent_next        = deb;
            end
            else
            begin
                res_next.action = kpsm_pkg::ACT_LEARN;
                idle_cnt_next   = '0;
            end
        end
        else
        begin
            hold_cnt_next  = '0;
            last_sent_next = '0;
        end

        res_next.debounced_key = deb;
        res_next.learn_mode    = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg  <= '0;
            mode_reg      <= 1'b0;
            idle_cnt_reg  <= '0;
            hold_cnt_reg  <= '0;
            last_sent_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_adv)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                prev_raw_reg  <= prev_raw_next;
                mode_reg      <= mode_next;
                idle_cnt_reg  <= idle_cnt_next;
                hold_cnt_reg  <= hold_cnt_next;
                last_sent_reg <= last_sent_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res_next;
    end

    assign m_tdata = {(kpsm_pkg::OUT_DATA_W - kpsm_pkg::RESULT_W)'(0), out_reg};

    // ---------------- assertions ----------------
    a_repeat_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.repeat_frame |-> out_reg.action == kpsm_pkg::ACT_SEND)
        else $error("repeat_frame without a send action");

    a_sleep_excludes_action: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.power_down |-> out_reg.action == kpsm_pkg::ACT_NONE)
        else $error("power_down together with an action");

    a_mode_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_reg.learn_mode == mode_reg)
        else $error("reported mode differs from mode state");

    a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while pipeline is full and stalled");

endmodule

`default_nettype wire

// File: verif/keypad_scan_mode_control_checker.sv
module keypad_scan_mode_control_checker #(
    parameter int KEY_COLUMNS = 4,
    parameter int KEY_ROWS    = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [8*KEY_COLUMNS-1:0]        s_tdata,    // [..0] key_matrix
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [5:0] debounced_key, [6] learn_mode, [8:7] action, [9] repeat_frame,
    // [10] power_down, rest zero
    input  wire logic [kpsm_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [kpsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kpsm_pkg::CFG_W-1:0]      cfg_wdata,
    output int                                   fail_count,
    output int                                   pending
);

    import kpsm_pkg::*;

    // config copy
    logic [KEY_CODE_W-1:0] pgm_code;
    logic [HOLD_W-1:0]     hold_limit;
    logic [IDLE_W-1:0]     idle_limit;

    // scanner state
    logic [KEY_CODE_W-1:0] prev_code;
    logic [KEY_CODE_W-1:0] last_sent;
    logic                  in_learn;
    logic [IDLE_W-1:0]     idle_ticks;
    logic [HOLD_W-1:0]     hold_ticks;

    result_t expected_results[$];
    int      results_seen;

    // lowest set bit wins: column first, then row
    function automatic logic [KEY_CODE_W-1:0] scan_code(input logic [8*KEY_COLUMNS-1:0] m);
        for (int c = 0; c < KEY_COLUMNS; c++)
            for (int r = 0; r < KEY_ROWS && r < 8; r++)
                if (m[8*c+r])
                    return KEY_CODE_W'(8*c + r + 1);
        return '0;
    endfunction

    task automatic predict_tick(input logic [8*KEY_COLUMNS-1:0] m, output result_t res);
        logic [KEY_CODE_W-1:0] raw;
        logic [KEY_CODE_W-1:0] deb;
        logic                  idle;
        logic                  rep;
        logic                  pd;
        action_t               act;
        raw  = scan_code(m);
        deb  = (raw == prev_code) ? raw : '0;
        idle = (raw == '0) && (prev_code == '0);
        act  = ACT_NONE;
        rep  = 1'b0;
        pd   = 1'b0;
        prev_code = raw;

        if (idle)
        begin
            if (!in_learn)
            begin
                pd = 1'b1;
            end
            else if (idle_ticks >= idle_limit)
            begin
                idle_ticks = '0;
                in_learn   = 1'b0;
                pd         = 1'b1;
            end
            else
            begin
                idle_ticks = idle_ticks + 1'b1;
            end
        end
        else
        begin
            idle_ticks = '0;
        end

        if (deb != '0)
        begin
            if (deb == pgm_code)
            begin
                in_learn = 1'b0;
                if (hold_ticks < HOLD_MAX)
                    hold_ticks = hold_ticks + 1'b1;
                if (hold_ticks > hold_limit)
                begin
                    idle_ticks = '0;
                    in_learn   = 1'b1;
                end
            end
            else if (!in_learn)
            begin
                act       = ACT_SEND;
                rep       = (deb == last_sent);
                last_sent = deb;
            end
            else
            begin
                act        = ACT_LEARN;
                idle_ticks = '0;
            end
        end
        else
        begin
            hold_ticks = '0;
            last_sent  = '0;
        end

        res               = '0;
        res.debounced_key = deb;
        res.learn_mode    = in_learn;
        res.action        = act;
        res.repeat_frame  = rep;
        res.power_down    = pd;
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            pgm_code   = RST_PROGRAM_KEY;
            hold_limit = RST_HOLD_THRESH;
            idle_limit = RST_IDLE_TMO;
            prev_code  = '0;
            last_sent  = '0;
            in_learn   = 1'b0;
            idle_ticks = '0;
            hold_ticks = '0;
            expected_results.delete();
            results_seen = 0;
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PROGRAM_KEY: pgm_code   = cfg_wdata[KEY_CODE_W-1:0];
                    REG_HOLD_THRESH: hold_limit = cfg_wdata[HOLD_W-1:0];
                    REG_IDLE_TMO:    idle_limit = cfg_wdata[IDLE_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                predict_tick(s_tdata, exp_r);
                expected_results.push_back(exp_r);
            end

            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0)
                begin
                    report("result with no item pending", 32'(m_tdata), 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.debounced_key !== want.debounced_key)
                        report("debounced_key", got.debounced_key, want.debounced_key);
                    if (got.learn_mode !== want.learn_mode)
                        report("learn_mode", got.learn_mode, want.learn_mode);
                    if (got.action !== want.action)
                        report("action", got.action, want.action);
                    if (got.repeat_frame !== want.repeat_frame)
                        report("repeat_frame", got.repeat_frame, want.repeat_frame);
                    if (got.power_down !== want.power_down)
                        report("power_down", got.power_down, want.power_down);
                    if (m_tdata[OUT_DATA_W-1:RESULT_W] !== '0)
                        report("padding", 32'(m_tdata[OUT_DATA_W-1:RESULT_W]), 0);
                end
                results_seen++;
            end

            pending = expected_results.size();
        end
    end

endmodule

// File: verif/keypad_scan_mode_control_tb.sv
module keypad_scan_mode_control_tb;

    import kpsm_pkg::*;

    // cycles with no item moving on either side before the run is abandoned
    localparam int QUIET_LIMIT = 1000;
    // pause after the last result before touching config (two-stage pipe)
    localparam int SETTLE_CYCLES = 4;
    // index 3 has no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;     // [31:0] key_matrix
    logic                  m_tvalid;
    logic                  m_tready;
    // [5:0] debounced_key, [6] learn_mode, [8:7] action, [9] repeat_frame,
    // [10] power_down, rest zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    int fail_count;
    int pending;
    int items_sent;
    int quiet_cycles;
    bit gapless;

    // current settings, kept only to shape the stimulus
    int cur_prog;
    int cur_hold;
    int cur_idle;

    keypad_scan_mode_control i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    keypad_scan_mode_control_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sender gaps: mostly back to back or short, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Matrix whose winning key is 'code': that bit set, random keys only above
    // it (higher bits lose the priority encode). Code 0 gives an empty matrix.
    function automatic logic [31:0] key_matrix(input int code);
        logic [31:0] one;
        logic [31:0] above;
        one = 32'd1;
        if (code < 1 || code > 32)
            return '0;
        above = ~((one << code) - one);
        return (one << (code - 1)) | (above & $urandom());
    endfunction

    // One scan tick. Called at a rising edge; returns at the edge that took it.
    // tvalid stays high between back-to-back items so it is never lowered and
    // raised within one step.
    task automatic send_tick(input logic [31:0] m);
        int gap;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Hold one key for n ticks, noise keys above it changing every tick.
    task automatic hold_key(input int code, input int n);
        repeat (n) send_tick(key_matrix(code));
    endtask

    task automatic idle_run(input int n);
        repeat (n) send_tick('0);
    endtask

    // Stop feeding, wait for every result, then let the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Register writes only with the block drained. Upper bits beyond a
    // register's width carry junk; the block must drop them.
    task automatic apply_config(input int prog, input int hold, input int idle_tmo,
                                input bit poke_unused);
        drain();
        write_reg(REG_PROGRAM_KEY, {6'($urandom), 6'(prog)});
        write_reg(REG_HOLD_THRESH, {4'($urandom), 8'(hold)});
        write_reg(REG_IDLE_TMO, 12'(idle_tmo));
        if (poke_unused)
            write_reg(REG_UNUSED, 12'($urandom));
        cfg_wr_en <= 1'b0;
        cur_prog = prog;
        cur_hold = hold;
        cur_idle = idle_tmo;
    endtask

    // Mostly well-formed key activity: holds long enough to debounce,
    // program key holds around the threshold, idle runs around the timeout,
    // with glitches and raw noise mixed in.
    task automatic random_segments(input int budget);
        int target;
        int k;
        int code;
        int n;
        target = items_sent + budget;
        while (items_sent < target)
        begin
            gapless = ($urandom_range(0, 4) == 0);
            k = $urandom_range(0, 99);
            if (k < 30)
            begin
                hold_key($urandom_range(1, 32), $urandom_range(1, 6));
            end
            else if (k < 50)
            begin
                code = (cur_prog >= 1 && cur_prog <= 32) ? cur_prog : $urandom_range(1, 32);
                n = (cur_hold <= 20) ? $urandom_range(1, cur_hold + 4) : $urandom_range(1, 6);
                hold_key(code, n);
            end
            else if (k < 70)
            begin
                n = (cur_idle <= 40) ? $urandom_range(1, cur_idle + 3) : $urandom_range(1, 8);
                idle_run(n);
            end
            else if (k < 85)
            begin
                repeat ($urandom_range(1, 3)) send_tick($urandom());
            end
            else
            begin
                // single-tick glitch: one tick of a random key
                send_tick(key_matrix($urandom_range(1, 32)));
            end
        end
    endtask

    // Receiver: ready runs mostly short with short stalls, sometimes a long
    // stall, and some long runs with no stall at all.
    initial
    begin
        int run_len;
        int stall_len;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            run_len   = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 8);
            stall_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            m_tready <= 1'b0;
            repeat (stall_len) @(posedge clk);
        end
    end

    // Watchdog: any accepted item on either side resets the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        quiet_cycles <= 0;
        items_sent   = 0;
        gapless      = 1'b0;
        cur_prog     = RST_PROGRAM_KEY;
        cur_hold     = RST_HOLD_THRESH;
        cur_idle     = RST_IDLE_TMO;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings (program key 6).
        send_tick('0);                      // idle in send mode: power down
        send_tick('0);
        send_tick(32'hFFFF_FFFF);           // everything pressed: key 1 wins
        send_tick(32'hFFFF_FFFF);           // debounced, send
        send_tick(32'hFFFF_FFFF);           // held: repeat frame
        send_tick(32'h8000_0000);           // top corner key 32
        send_tick(32'h8000_0000);
        send_tick(32'h8000_0000);
        send_tick(32'h0000_0080);           // last row of first column
        send_tick(32'h0000_0080);
        send_tick(32'h0000_0100);           // first row of second column
        send_tick(32'h0000_0100);
        send_tick(32'h0100_0000);           // first row of last column
        send_tick(32'h0100_0000);
        send_tick(32'h0000_0020);           // program key held: no action
        send_tick(32'h0000_0020);
        send_tick(32'h0000_0020);
        send_tick(32'h0000_0001);           // key change breaks debounce
        send_tick(32'h0000_0002);
        idle_run(3);

        // Reset thresholds: hold program key past 100 into learn mode, learn
        // a key, then idle a while in learn mode.
        hold_key(RST_PROGRAM_KEY, 102);
        hold_key(3, 3);
        idle_run(8);
        random_segments(15);

        // Zero thresholds: learn on the first debounced program key tick, time out on
        // the first idle learn tick.
        apply_config(1, 0, 0, 1'b1);
        random_segments(30);

        // Threshold 255: the hold counter saturates, learn mode never comes.
        apply_config(32, 255, 4095, 1'b0);
        hold_key(32, 258);
        random_segments(10);

        // Largest idle timeout: learn mode at once, idle ticks keep it.
        apply_config(20, 0, 4095, 1'b0);
        hold_key(20, 3);
        idle_run(10);

        // Program key codes that can never match a key.
        apply_config(0, 1, 1, 1'b0);
        random_segments(20);
        apply_config(63, 2, 3, 1'b1);
        random_segments(20);

        repeat (3)
        begin
            apply_config(($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                     : $urandom_range(1, 32),
                         $urandom_range(0, 12), $urandom_range(0, 40), 1'b0);
            random_segments(15);
        end

        // back to reset values by explicit writes
        apply_config(RST_PROGRAM_KEY, RST_HOLD_THRESH, RST_IDLE_TMO, 1'b0);
        random_segments(10);

        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
